// ----- rtl/bdq_pkg.sv -----
// Package for the bounded deque unit: depth, derived widths, request and status codes,
// the FSM state type and the ring slot helper. It has no dependencies.
package bdq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned PtrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned IdxW  = 4;
  localparam int unsigned CmpW  = (CntW > IdxW) ? CntW : IdxW;
  localparam int unsigned WordW = 32;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_REMOVE_AT  = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_POP_BACK   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_FETCH = 4'b0100,
    ST_SHIFT = 4'b1000
  } state_e;

  localparam logic [WordW-1:0] FAIL_WORD = '1;

  // (base + off) mod DEPTH, both operands already below DEPTH
  function automatic logic [PtrW-1:0] slot_add(input logic [PtrW-1:0] base,
                                               input logic [PtrW-1:0] off);
    logic [PtrW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (PtrW+1)'(DEPTH)) begin
      sum = sum - (PtrW+1)'(DEPTH);
    end
    return sum[PtrW-1:0];
  endfunction

endpackage

// ----- rtl/bounded_deque_with_indexed_remove_unit.sv -----
// Top level of the bounded deque unit: sequencer, ring store and result register.
// Depends on bdq_pkg.
//
// Bounded double-ended queue of DEPTH (16) signed 32-bit words in a ring store.
// Raise start with mode_i/value_i/index_i while busy is low; that beat is taken
// and busy rises the next cycle. Exactly one result comes back per request: done_o
// is high for one cycle with removed_value_o, status_o and occupancy_o valid in that
// cycle only. The receiver cannot stall, so capture it then. busy is already low in
// the done_o cycle, so a new request may start there. Pushes, rejected requests and
// unused modes finish in the execute state; remove first / remove last read the slot
// and then finish; remove at index also reads the removed slot, then the entries behind
// the hole move down one slot per cycle through the store, which has one write port and
// one registered read port (read one slot ahead, write the previous one). Worst case is
// index 0 on a full deque. Status codes: ok, empty, index out of range, full. A failed
// removal returns all ones (-1); pushes return 0. The store has no reset; only slots
// that a push wrote are ever read back.
module bounded_deque_with_indexed_remove_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [2:0]                              mode_i,
  input  logic signed [bdq_pkg::WordW-1:0]        value_i,
  input  logic [bdq_pkg::IdxW-1:0]                index_i,
  output logic                                    done_o,
  output logic signed [bdq_pkg::WordW-1:0]        removed_value_o,
  output logic [1:0]                              status_o,
  output logic [bdq_pkg::CntW-1:0]                occupancy_o
);

  // request latch
  logic [2:0]                     mode_q;
  logic [bdq_pkg::WordW-1:0]      value_q;
  logic [bdq_pkg::IdxW-1:0]       index_q;

  // deque state
  bdq_pkg::state_e                state_q, state_d;
  logic [bdq_pkg::PtrW-1:0]       front_q, front_d;
  logic [bdq_pkg::CntW-1:0]       count_q, count_d;
  logic [bdq_pkg::PtrW-1:0]       ptr_q, ptr_d;       // logical position being refilled
  logic [bdq_pkg::WordW-1:0]      rem_q, rem_d;       // word taken by remove at index

  // store port
  logic [bdq_pkg::WordW-1:0]      mem [bdq_pkg::DEPTH];
  logic [bdq_pkg::PtrW-1:0]       rd_addr;
  logic [bdq_pkg::WordW-1:0]      rd_data_q;
  logic                           wr_en;
  logic [bdq_pkg::PtrW-1:0]       wr_addr;
  logic [bdq_pkg::WordW-1:0]      wr_data;

  // result beat
  logic                           done_q, done_d;
  logic [bdq_pkg::WordW-1:0]      rv_q, rv_d;
  logic [1:0]                     st_q, st_d;
  logic [bdq_pkg::CntW-1:0]       occ_q;

  logic                           accept;
  logic [bdq_pkg::CmpW-1:0]       idx_cmp, cnt_cmp;
  logic [bdq_pkg::CntW-1:0]       ptr_ext;

  assign accept  = start && !busy;
  assign busy    = (state_q != bdq_pkg::ST_IDLE);
  assign idx_cmp = bdq_pkg::CmpW'(index_q);
  assign cnt_cmp = bdq_pkg::CmpW'(count_q);
  assign ptr_ext = bdq_pkg::CntW'(ptr_q);

  always_comb begin
    state_d = state_q;
    front_d = front_q;
    count_d = count_q;
    ptr_d   = ptr_q;
    rem_d   = rem_q;
    rd_addr = front_q;
    wr_en   = 1'b0;
    wr_addr = front_q;
    wr_data = value_q;
    done_d  = 1'b0;
    rv_d    = '0;
    st_d    = bdq_pkg::STAT_OK;

    unique case (state_q)
      bdq_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = bdq_pkg::ST_EXEC;
        end
      end

      bdq_pkg::ST_EXEC: begin
        // default: finish this cycle; removals that reach the store override below
        state_d = bdq_pkg::ST_IDLE;
        done_d  = 1'b1;
        unique case (mode_q)
          bdq_pkg::MODE_PUSH_FRONT, bdq_pkg::MODE_PUSH_BACK: begin
            if (count_q == bdq_pkg::CntW'(bdq_pkg::DEPTH)) begin
              st_d = bdq_pkg::STAT_FULL;
            end else begin
              wr_en   = 1'b1;
              count_d = count_q + 1'b1;
              if (mode_q == bdq_pkg::MODE_PUSH_FRONT) begin
                front_d = (front_q == '0) ? bdq_pkg::PtrW'(bdq_pkg::DEPTH - 1)
                                          : front_q - 1'b1;
                wr_addr = front_d;
              end else begin
                wr_addr = bdq_pkg::slot_add(front_q, bdq_pkg::PtrW'(count_q));
              end
            end
          end
          bdq_pkg::MODE_REMOVE_AT, bdq_pkg::MODE_POP_FRONT, bdq_pkg::MODE_POP_BACK: begin
            if (count_q == '0) begin
              st_d = bdq_pkg::STAT_EMPTY;
              rv_d = bdq_pkg::FAIL_WORD;
            end else if (mode_q == bdq_pkg::MODE_REMOVE_AT && idx_cmp >= cnt_cmp) begin
              st_d = bdq_pkg::STAT_RANGE;
              rv_d = bdq_pkg::FAIL_WORD;
            end else begin
              done_d  = 1'b0;
              state_d = bdq_pkg::ST_FETCH;
              if (mode_q == bdq_pkg::MODE_REMOVE_AT) begin
                ptr_d   = bdq_pkg::PtrW'(idx_cmp);
                rd_addr = bdq_pkg::slot_add(front_q, ptr_d);
              end else if (mode_q == bdq_pkg::MODE_POP_BACK) begin
                rd_addr = bdq_pkg::slot_add(front_q, bdq_pkg::PtrW'(count_q - 1'b1));
              end else begin
                rd_addr = front_q;
              end
            end
          end
          default: begin
            // unused modes: no change, status ok, word 0
          end
        endcase
      end

      bdq_pkg::ST_FETCH: begin
        // rd_data_q holds the removed word
        if (mode_q == bdq_pkg::MODE_REMOVE_AT && (ptr_ext + 1'b1) < count_q) begin
          rem_d   = rd_data_q;
          rd_addr = bdq_pkg::slot_add(front_q, bdq_pkg::PtrW'(ptr_ext + 1'b1));
          state_d = bdq_pkg::ST_SHIFT;
        end else begin
          if (mode_q == bdq_pkg::MODE_POP_FRONT) begin
            front_d = bdq_pkg::slot_add(front_q, bdq_pkg::PtrW'(1));
          end
          count_d = count_q - 1'b1;
          rv_d    = rd_data_q;
          done_d  = 1'b1;
          state_d = bdq_pkg::ST_IDLE;
        end
      end

      bdq_pkg::ST_SHIFT: begin
        // rd_data_q holds position ptr+1; drop it into position ptr
        wr_en   = 1'b1;
        wr_addr = bdq_pkg::slot_add(front_q, ptr_q);
        wr_data = rd_data_q;
        ptr_d   = ptr_q + 1'b1;
        if ((ptr_ext + 2'd2) < count_q) begin
          rd_addr = bdq_pkg::slot_add(front_q, bdq_pkg::PtrW'(ptr_ext + 2'd2));
        end else begin
          count_d = count_q - 1'b1;
          rv_d    = rem_q;
          done_d  = 1'b1;
          state_d = bdq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bdq_pkg::ST_IDLE;
      end
    endcase
  end

  // ring store: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  // request latch and payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      value_q <= value_i;
      index_q <= index_i;
    end
    ptr_q <= ptr_d;
    rem_q <= rem_d;
    if (done_d) begin
      rv_q  <= rv_d;
      st_q  <= st_d;
      occ_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdq_pkg::ST_IDLE;
      front_q <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  assign done_o          = done_q;
  assign removed_value_o = rv_q;
  assign status_o        = st_q;
  assign occupancy_o     = occ_q;

endmodule

// ----- rtl/bdq_checker.sv -----
// Port-level checker for the bounded deque unit, bound to the top level.
// Depends on bdq_pkg.
module bdq_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             done_o,
  input logic [bdq_pkg::WordW-1:0]        removed_value_o,
  input logic [1:0]                       status_o,
  input logic [bdq_pkg::CntW-1:0]         occupancy_o
);

  // a taken beat makes the unit busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted beat");

  // the result beat closes the request: unit is free in that cycle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(busy)))
    else $error("result beat without a pending request");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (occupancy_o <= bdq_pkg::CntW'(bdq_pkg::DEPTH)))
    else $error("occupancy above depth");

  a_fail_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == bdq_pkg::STAT_EMPTY || status_o == bdq_pkg::STAT_RANGE))
      |-> (removed_value_o == bdq_pkg::FAIL_WORD))
    else $error("failed removal must return all ones");

  a_full_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == bdq_pkg::STAT_FULL)
      |-> (removed_value_o == '0 && occupancy_o == bdq_pkg::CntW'(bdq_pkg::DEPTH)))
    else $error("rejected push must return zero at full occupancy");

endmodule

bind bounded_deque_with_indexed_remove_unit bdq_checker u_bdq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .removed_value_o (removed_value_o),
  .status_o        (status_o),
  .occupancy_o     (occupancy_o)
);
